>>> sv/tcwqa_pkg.sv
// Package for the two-class weighted queue arbiter.
// Widths, constants, controller state type and controller/datapath structs.
// No dependencies.
`default_nettype none

package tcwqa_pkg;

  localparam int QD_DEFAULT = 16;

  localparam int ID_W    = 16;
  localparam int AGE_W   = 8;
  localparam int LIMIT_W = 8;
  localparam int ENTRY_W = ID_W + AGE_W;

  localparam logic [AGE_W-1:0]   AGE_THRESHOLD = AGE_W'(60);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_stall;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/tcwqa_in_if.sv
// Input channel of the arbiter: add or serve requests.
// Depends on tcwqa_pkg.
`default_nettype none

interface tcwqa_in_if
  import tcwqa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [ID_W-1:0]  entry_id;
  logic [AGE_W-1:0] entry_age;

  modport source (output valid, output operation, output entry_id, output entry_age,
                  input ready);
  modport sink   (input valid, input operation, input entry_id, input entry_age,
                  output ready);
endinterface

`default_nettype wire

>>> sv/tcwqa_out_if.sv
// Result channel of the arbiter: one beat per request.
// Depends on tcwqa_pkg.
`default_nettype none

interface tcwqa_out_if
  import tcwqa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             served_valid;
  logic [ID_W-1:0]  served_id;
  logic [AGE_W-1:0] served_age;
  logic             served_priority;
  logic             add_dropped;

  modport source (output valid, output served_valid, output served_id, output served_age,
                  output served_priority, output add_dropped, input ready);
  modport sink   (input valid, input served_valid, input served_id, input served_age,
                  input served_priority, input add_dropped, output ready);
endinterface

`default_nettype wire

>>> sv/tcwqa_ctrl.sv
// Controller FSM: accepts a request, then loads the result register.
// Depends on tcwqa_pkg.
`default_nettype none

module tcwqa_ctrl
  import tcwqa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!stat.out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcwqa_dp.sv
// Datapath: both FIFO memories, pointers, run counter, limit register, result register.
// Depends on tcwqa_pkg; driven by tcwqa_ctrl commands.
`default_nettype none

module tcwqa_dp
  import tcwqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = QD_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  input  wire logic               in_operation,
  input  wire logic [ID_W-1:0]    in_entry_id,
  input  wire logic [AGE_W-1:0]   in_entry_age,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_served_valid,
  output logic [ID_W-1:0]         out_served_id,
  output logic [AGE_W-1:0]        out_served_age,
  output logic                    out_served_priority,
  output logic                    out_add_dropped
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [AW:0]   DEPTH_C = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

  logic [ENTRY_W-1:0] pmem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] nmem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] prd_r, nrd_r;

  logic [AW-1:0]      phead_r, phead_nxt, nhead_r, nhead_nxt;
  logic [AW:0]        pfill_r, pfill_nxt, nfill_r, nfill_nxt;
  logic [LIMIT_W-1:0] run_r, run_nxt, limit_r;

  logic valid_r, valid_nxt, prio_r, prio_nxt, drop_r, drop_nxt;
  logic p_we, n_we;
  logic [AW-1:0] ptail, ntail;
  logic [AW:0]   psum, nsum;
  logic          to_prio, take_prio;

  logic                out_valid_r;
  logic                o_sv_r, o_pr_r, o_dr_r;
  logic [ID_W-1:0]     o_id_r;
  logic [AGE_W-1:0]    o_age_r;
  logic [ENTRY_W-1:0]  sel_rd;

  // tail = (head + fill) mod depth
  assign psum  = {1'b0, phead_r} + pfill_r;
  assign nsum  = {1'b0, nhead_r} + nfill_r;
  assign ptail = (psum >= DEPTH_C) ? AW'(psum - DEPTH_C) : psum[AW-1:0];
  assign ntail = (nsum >= DEPTH_C) ? AW'(nsum - DEPTH_C) : nsum[AW-1:0];

  assign to_prio   = in_entry_age > AGE_THRESHOLD;
  assign take_prio = (run_r < limit_r) && (pfill_r != '0);

  always_comb begin
    phead_nxt = phead_r;
    nhead_nxt = nhead_r;
    pfill_nxt = pfill_r;
    nfill_nxt = nfill_r;
    run_nxt   = run_r;
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    drop_nxt  = drop_r;
    p_we      = 1'b0;
    n_we      = 1'b0;
    if (cmd.accept) begin
      valid_nxt = 1'b0;
      prio_nxt  = 1'b0;
      drop_nxt  = 1'b0;
      if (in_operation == OP_ADD) begin
        if (to_prio) begin
          if (pfill_r == DEPTH_C) begin
            drop_nxt = 1'b1;
          end else begin
            p_we      = 1'b1;
            pfill_nxt = pfill_r + 1'b1;
          end
        end else begin
          if (nfill_r == DEPTH_C) begin
            drop_nxt = 1'b1;
          end else begin
            n_we      = 1'b1;
            nfill_nxt = nfill_r + 1'b1;
          end
        end
      end else begin
        if (take_prio) begin
          valid_nxt = 1'b1;
          prio_nxt  = 1'b1;
          run_nxt   = run_r + 1'b1;
          pfill_nxt = pfill_r - 1'b1;
          phead_nxt = (phead_r == LAST_C) ? '0 : phead_r + 1'b1;
        end else begin
          run_nxt = '0;
          if (nfill_r != '0) begin
            valid_nxt = 1'b1;
            nfill_nxt = nfill_r - 1'b1;
            nhead_nxt = (nhead_r == LAST_C) ? '0 : nhead_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phead_r <= '0;
      nhead_r <= '0;
      pfill_r <= '0;
      nfill_r <= '0;
      run_r   <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      phead_r <= phead_nxt;
      nhead_r <= nhead_nxt;
      pfill_r <= pfill_nxt;
      nfill_r <= nfill_nxt;
      run_r   <= run_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    valid_r <= valid_nxt;
    prio_r  <= prio_nxt;
    drop_r  <= drop_nxt;
  end

  // Head entries are read at the accept beat and held until the next one.
  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[ptail] <= {in_entry_id, in_entry_age};
    end
    if (cmd.accept) begin
      prd_r <= pmem[phead_r];
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[ntail] <= {in_entry_id, in_entry_age};
    end
    if (cmd.accept) begin
      nrd_r <= nmem[nhead_r];
    end
  end

  assign sel_rd = prio_r ? prd_r : nrd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      o_sv_r  <= valid_r;
      o_pr_r  <= valid_r & prio_r;
      o_dr_r  <= drop_r;
      o_id_r  <= valid_r ? sel_rd[ENTRY_W-1:AGE_W] : '0;
      o_age_r <= valid_r ? sel_rd[AGE_W-1:0] : '0;
    end
  end

  assign stat.out_stall      = out_valid_r & ~out_ready;
  assign out_valid           = out_valid_r;
  assign out_served_valid    = o_sv_r;
  assign out_served_id       = o_id_r;
  assign out_served_age      = o_age_r;
  assign out_served_priority = o_pr_r;
  assign out_add_dropped     = o_dr_r;

endmodule

`default_nettype wire

>>> sv/two_class_weighted_queue_arbiter.sv
// Two-class weighted queue arbiter, top level.
// The result beat is registered: a request is accepted and the head entries read, then
// the result register is loaded once out_ch is not stalled; only then is a new request accepted.
// A result waiting on out_ch does not block the next accept; only its load waits.
// Synchronous active-low reset empties both FIFOs, clears the run counter, limit = 1.
// Depends on tcwqa_pkg, tcwqa_in_if, tcwqa_out_if, tcwqa_ctrl, tcwqa_dp.
`default_nettype none

module two_class_weighted_queue_arbiter
  import tcwqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = QD_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  tcwqa_in_if.sink                in_ch,
  tcwqa_out_if.source             out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tcwqa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcwqa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_ch.operation),
    .in_entry_id         (in_ch.entry_id),
    .in_entry_age        (in_ch.entry_age),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_served_valid    (out_ch.served_valid),
    .out_served_id       (out_ch.served_id),
    .out_served_age      (out_ch.served_age),
    .out_served_priority (out_ch.served_priority),
    .out_add_dropped     (out_ch.add_dropped)
  );

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.served_valid && out_ch.add_dropped))
    else $error("served and dropped in one beat");

  a_prio_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.served_priority |-> out_ch.served_valid)
    else $error("priority flag without served entry");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.served_valid |-> out_ch.served_id == '0 && out_ch.served_age == '0)
    else $error("nonzero payload on empty serve");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second request taken before result load");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for two_class_weighted_queue_arbiter: random add/serve
// traffic, run-limit changes and back-pressure, checked beat by beat by a scoreboard.
// Depends on tcwqa_pkg, tcwqa_in_if, tcwqa_out_if and the arbiter RTL.
`default_nettype none

module tb_top
  import tcwqa_pkg::*;
();

  localparam int DEPTH        = 16;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT      = 3_000_000;

  typedef struct packed {
    logic             served_valid;
    logic [ID_W-1:0]  served_id;
    logic [AGE_W-1:0] served_age;
    logic             served_priority;
    logic             add_dropped;
  } result_t;

  class served_scoreboard;
    logic [ID_W-1:0]    prio_ids[$];
    logic [AGE_W-1:0]   prio_ages[$];
    logic [ID_W-1:0]    norm_ids[$];
    logic [AGE_W-1:0]   norm_ages[$];
    logic [LIMIT_W-1:0] run_limit;
    logic [LIMIT_W-1:0] run_count;
    result_t            expected_results[$];
    int errors, n_adds, n_serves, n_drops, n_prio, n_empty;

    function new();
      run_limit = LIMIT_RESET;
      run_count = '0;
    endfunction

    function void note_request(logic op, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
      result_t r;
      r = '0;
      if (op == OP_ADD) begin
        n_adds++;
        if (age > AGE_THRESHOLD) begin
          if (prio_ids.size() >= DEPTH) begin
            r.add_dropped = 1'b1;
          end else begin
            prio_ids.push_back(id);
            prio_ages.push_back(age);
          end
        end else begin
          if (norm_ids.size() >= DEPTH) begin
            r.add_dropped = 1'b1;
          end else begin
            norm_ids.push_back(id);
            norm_ages.push_back(age);
          end
        end
        if (r.add_dropped) n_drops++;
      end else begin
        n_serves++;
        if (run_count < run_limit && prio_ids.size() != 0) begin
          r.served_valid    = 1'b1;
          r.served_id       = prio_ids.pop_front();
          r.served_age      = prio_ages.pop_front();
          r.served_priority = 1'b1;
          run_count         = run_count + 1'b1;
          n_prio++;
        end else begin
          run_count = '0;
          if (norm_ids.size() != 0) begin
            r.served_valid = 1'b1;
            r.served_id    = norm_ids.pop_front();
            r.served_age   = norm_ages.pop_front();
          end else begin
            n_empty++;
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.served_valid !== want.served_valid) begin
        $error("served_valid: expected %0d, got %0d", want.served_valid, got.served_valid);
        errors++;
      end
      if (got.served_id !== want.served_id) begin
        $error("served_id: expected %h, got %h", want.served_id, got.served_id);
        errors++;
      end
      if (got.served_age !== want.served_age) begin
        $error("served_age: expected %0d, got %0d", want.served_age, got.served_age);
        errors++;
      end
      if (got.served_priority !== want.served_priority) begin
        $error("served_priority: expected %0d, got %0d", want.served_priority,
               got.served_priority);
        errors++;
      end
      if (got.add_dropped !== want.add_dropped) begin
        $error("add_dropped: expected %0d, got %0d", want.add_dropped, got.add_dropped);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  tcwqa_in_if  in_ch();
  tcwqa_out_if out_ch();

  two_class_weighted_queue_arbiter #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  served_scoreboard sb = new();

  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  logic    hold_req       = 1'b0;
  int      holds_done     = 0;
  int      limits_used    = 0;
  result_t seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    int held;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        held         = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        holds_done++;
      end
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.served_valid    = out_ch.served_valid;
      seen.served_id       = out_ch.served_id;
      seen.served_age      = out_ch.served_age;
      seen.served_priority = out_ch.served_priority;
      seen.add_dropped     = out_ch.add_dropped;
      sb.check_result(seen);
    end
  end

  // called at a falling edge; returns at the falling edge after the accepting beat
  task automatic send_request(logic op, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.entry_id  = id;
    in_ch.entry_age = age;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, id, age);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    sb.run_limit = value;
    limits_used++;
  endtask

  task automatic random_request(int add_pct);
    logic             op;
    logic [ID_W-1:0]  id;
    logic [AGE_W-1:0] age;
    op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_SERVE;
    id = ID_W'($urandom);
    case ($urandom_range(7))
      0: age = AGE_THRESHOLD;
      1: age = AGE_THRESHOLD + 1'b1;
      2: age = '0;
      3: age = '1;
      4, 5: age = AGE_W'($urandom_range(60));
      default: age = AGE_W'($urandom_range(255, 61));
    endcase
    send_request(op, id, age);
  endtask

  // each burst picks a random add mix (mostly adds, even, or mostly serves) so both queues overflow and empty
  task automatic run_phase(int n_items, int idle_pct, int stall_pct, bit with_hold);
    int seg_left;
    int add_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    seg_left       = 0;
    add_pct        = 50;
    for (int i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 10);
        case ($urandom_range(2))
          0: add_pct = 95;
          1: add_pct = 50;
          default: add_pct = 10;
        endcase
      end
      if (with_hold && i == 20) hold_req = 1'b1;
      random_request(add_pct);
      seg_left--;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.entry_id  = '0;
    in_ch.entry_age = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset limit of one: alternate priority and normal, then run dry
    send_request(OP_SERVE, '1, '1);
    send_request(OP_ADD, 16'h0000, AGE_THRESHOLD);
    send_request(OP_ADD, 16'hFFFF, AGE_THRESHOLD + 1'b1);
    send_request(OP_ADD, 16'h5A5A, 8'd0);
    send_request(OP_ADD, 16'hA5A5, 8'd255);
    send_request(OP_ADD, 16'h1234, 8'd200);
    repeat (6) send_request(OP_SERVE, 16'h0000, 8'd0);
    run_phase(100, 0, 0, 1'b0);

    write_limit(8'd0);
    send_request(OP_ADD, 16'hBEEF, 8'd99);
    send_request(OP_SERVE, '0, '0);
    run_phase(115, 47, 0, 1'b0);

    write_limit(8'd255);
    run_phase(115, 0, 47, 1'b0);
    run_phase(60, 0, 0, 1'b1);

    // lowering the limit below the running count forces the normal path
    write_limit(8'd2);
    run_phase(115, 25, 25, 1'b0);

    write_limit(LIMIT_W'($urandom_range(8, 3)));
    run_phase(115, 0, 0, 1'b0);

    write_limit(8'd1);
    run_phase(100, 25, 25, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d adds (%0d dropped) and %0d serves (%0d priority, %0d empty)",
             sb.n_adds, sb.n_drops, sb.n_serves, sb.n_prio, sb.n_empty);
    $display("across %0d limit writes and %0d long output hold-off(s)",
             limits_used, holds_done);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
